[rtl/snd_pkg.sv]
// ----------------------------------------------------------------------------
// snd_pkg: shared constants and types for the 2D simplex noise pipeline
// Register codes, reset values, stage counts and the gradient record.
// ----------------------------------------------------------------------------
package snd_pkg;

  localparam int DIR_COUNT_DEF = 16;

  localparam logic [31:0] HASH_MUL = 32'd22695477;

  localparam logic [15:0] SKEW_RST   = 16'd23984;
  localparam logic [15:0] UNSKEW_RST = 16'd13849;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SKEW   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNSKEW = 1'b1;

  localparam logic [32:0] HALF_Q32 = 33'h0_8000_0000;

  // sample tokens live in S1..S15, load tokens in S1..S11 (table write stage)
  localparam int SMP_STAGES = 15;
  localparam int LD_STAGES  = 11;
  localparam int AI_DELAY   = 5;

  // per-corner delay lines: offsets S5..S12, falloff S9..S14
  localparam int DX_DELAY = 8;
  localparam int M4_DELAY = 6;

  localparam int CORNERS = 3;

  typedef struct packed {
    logic signed [15:0] gy;
    logic signed [15:0] gx;
  } grad_t;

endpackage

[rtl/simplex_noise_2d.sv]
// ----------------------------------------------------------------------------
// simplex_noise_2d: pipelined 2D simplex noise in fixed point
// Skew, corner selection, lattice hashing, gradient lookup and falloff
// summed over three corners per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_command = 1 samples noise at
//   (in_x_coord, in_y_coord), Q16.16; in_command = 0 loads direction entry
//   in_entry_index with (in_dir_x, in_dir_y), Q1.14, and returns nothing.
//   Output channel (out_valid/out_ready): one out_noise_value per sample,
//   Q2.30, in input order.
//   Configuration: cfg_we writes cfg_wdata to skew (index 0) or unskew
//   (index 1); write only while no item is in flight.
//   One item enters per cycle while no result waits on a stalled receiver;
//   the rate is set by the 16-stage pipeline with three corner lanes and
//   three replicated direction tables read in parallel.
//   A load writes the table from stage S11, in order with samples around it.
//   Reset clears the pipeline tokens and out_valid, sets the factors to their
//   defaults and the direction table to zero (valid bits per entry).
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module simplex_noise_2d #(
  parameter int DirCount = snd_pkg::DIR_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_command,
  input  logic signed [31:0]               in_x_coord,
  input  logic signed [31:0]               in_y_coord,
  input  logic [3:0]                       in_entry_index,
  input  logic signed [15:0]               in_dir_x,
  input  logic signed [15:0]               in_dir_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               out_noise_value,
  input  logic                             cfg_we,
  input  logic [snd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_wdata
);

  localparam int IdxW    = $clog2(DirCount);
  localparam int RemW    = IdxW + 1;
  localparam int SmpN    = snd_pkg::SMP_STAGES;
  localparam int LdN     = snd_pkg::LD_STAGES;
  localparam int AiN     = snd_pkg::AI_DELAY;
  localparam int Corners = snd_pkg::CORNERS;

  logic        en;
  logic [15:0] skew_r, unskew_r;

  logic [SmpN-1:0]     smp_r;
  logic [LdN-1:0]      ld_r;
  logic                ld_ok;
  logic [IdxW-1:0]     ld_idx_r [LdN];
  logic [31:0]         ld_dat_r [LdN];
  logic [DirCount-1:0] dvalid_r;

  // S1
  logic signed [32:0] sxy;
  logic signed [49:0] pxy1_r, pxy1_nxt;
  logic signed [31:0] x1_r, y1_r;
  // S2
  logic signed [33:0] s_sk, sx, sy;
  logic signed [17:0] i2_r, j2_r;
  logic               ai2_r, ai2_nxt;
  logic signed [31:0] x2_r, y2_r;
  logic signed [18:0] ip1, jp1;
  logic signed [18:0] ca [Corners];
  logic signed [18:0] cb [Corners];
  logic               ai_d_r [AiN];
  // S6 / S7
  logic [IdxW-1:0] hi0, hi1, hj0, hj1;
  logic [IdxW-1:0] htab [DirCount];
  logic [IdxW-1:0] hi0_7_r, hi1_7_r, hhj0_7_r, hhj1_7_r;
  logic [RemW-1:0] csum [Corners];
  // S11 / S12
  logic [IdxW-1:0]       gidx [Corners];
  logic [31:0]           rdata [Corners];
  logic [Corners-1:0]    gv12_r;
  snd_pkg::grad_t        grad [Corners];
  logic signed [63:0]    term [Corners];
  logic                  tbl_we;
  // output
  logic                  out_valid_r;
  logic signed [31:0]    out_noise_r;
  logic signed [63:0]    sum_all;

  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;
  assign ld_ok    = 32'(in_entry_index) < 32'(DirCount);
  assign tbl_we   = en & ld_r[LdN-1];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skew_r   <= snd_pkg::SKEW_RST;
      unskew_r <= snd_pkg::UNSKEW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        snd_pkg::REG_SKEW:   skew_r   <= cfg_wdata;
        snd_pkg::REG_UNSKEW: unskew_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r       <= '0;
      ld_r        <= '0;
      out_valid_r <= 1'b0;
      dvalid_r    <= '0;
    end else if (en) begin
      smp_r       <= {smp_r[SmpN-2:0], in_valid & in_command};
      ld_r        <= {ld_r[LdN-2:0], in_valid & ~in_command & ld_ok};
      out_valid_r <= smp_r[SmpN-1];
      if (ld_r[LdN-1]) begin
        dvalid_r[ld_idx_r[LdN-1]] <= 1'b1;
      end
    end
  end

  // skew: S1 multiply, S2 floor and corner choice
  assign sxy      = 33'(in_x_coord) + 33'(in_y_coord);
  assign pxy1_nxt = sxy * $signed({1'b0, skew_r});
  assign s_sk     = pxy1_r[49:16];
  assign sx       = 34'(x1_r) + s_sk;
  assign sy       = 34'(y1_r) + s_sk;
  assign ai2_nxt  = sx[15:0] > sy[15:0];

  assign ip1   = 19'(i2_r) + 19'sd1;
  assign jp1   = 19'(j2_r) + 19'sd1;
  assign ca[0] = 19'(i2_r);
  assign cb[0] = 19'(j2_r);
  assign ca[1] = ai2_r ? ip1 : 19'(i2_r);
  assign cb[1] = ai2_r ? 19'(j2_r) : jp1;
  assign ca[2] = ip1;
  assign cb[2] = jp1;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= in_x_coord;
      y1_r   <= in_y_coord;
      pxy1_r <= pxy1_nxt;
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      i2_r   <= sx[33:16];
      j2_r   <= sy[33:16];
      ai2_r  <= ai2_nxt;
      ai_d_r[0] <= ai2_r;
      for (int k = 1; k < AiN; k++) begin
        ai_d_r[k] <= ai_d_r[k-1];
      end
      ld_idx_r[0] <= IdxW'(in_entry_index);
      ld_dat_r[0] <= {in_dir_y, in_dir_x};
      for (int k = 1; k < LdN; k++) begin
        ld_idx_r[k] <= ld_idx_r[k-1];
        ld_dat_r[k] <= ld_dat_r[k-1];
      end
    end
  end

  // first-level hashes, S3..S6
  snd_hash #(.DirCount(DirCount)) u_hash_i0 (
    .clk(clk), .en(en), .key_i(32'(i2_r)), .hash_o(hi0));
  snd_hash #(.DirCount(DirCount)) u_hash_i1 (
    .clk(clk), .en(en), .key_i(32'(ip1)), .hash_o(hi1));
  snd_hash #(.DirCount(DirCount)) u_hash_j0 (
    .clk(clk), .en(en), .key_i(32'(j2_r)), .hash_o(hj0));
  snd_hash #(.DirCount(DirCount)) u_hash_j1 (
    .clk(clk), .en(en), .key_i(32'(jp1)), .hash_o(hj1));

  // second hash of a small value as a constant table
  for (genvar g = 0; g < DirCount; g++) begin : g_htab
    localparam logic [31:0] HashW = 32'(64'd22695477 * 64'(g) + 64'd1);
    localparam longint HashS = longint'($signed(HashW));
    localparam longint HashM = HashS % DirCount;
    localparam longint HashR = (HashM < 0) ? HashM + DirCount : HashM;
    assign htab[g] = IdxW'(HashR);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi0_7_r  <= hi0;
      hi1_7_r  <= hi1;
      hhj0_7_r <= htab[hj0];
      hhj1_7_r <= htab[hj1];
    end
  end

  assign csum[0] = RemW'(hi0_7_r) + RemW'(hhj0_7_r);
  assign csum[1] = ai_d_r[AiN-1] ? RemW'(hi1_7_r) + RemW'(hhj0_7_r)
                                 : RemW'(hi0_7_r) + RemW'(hhj1_7_r);
  assign csum[2] = RemW'(hi1_7_r) + RemW'(hhj1_7_r);

  for (genvar c = 0; c < Corners; c++) begin : g_corner
    // final hash S8..S11
    snd_hash #(.DirCount(DirCount)) u_hash_c (
      .clk(clk), .en(en), .key_i(32'(csum[c])), .hash_o(gidx[c]));

    // table replica, read at S11, data at S12
    snd_ram #(.Width(32), .Depth(DirCount)) u_dir_ram (
      .clk(clk), .we(tbl_we), .waddr(ld_idx_r[LdN-1]), .wdata(ld_dat_r[LdN-1]),
      .re(en), .raddr(gidx[c]), .rdata(rdata[c]));

    always_ff @(posedge clk) begin
      if (en) begin
        gv12_r[c] <= dvalid_r[gidx[c]];
      end
    end

    assign grad[c] = gv12_r[c] ? snd_pkg::grad_t'(rdata[c]) : '0;

    snd_corner u_corner (
      .clk(clk), .en(en), .x_i(x2_r), .y_i(y2_r), .a_i(ca[c]), .b_i(cb[c]),
      .g2_i(unskew_r), .grad_i(grad[c]), .term_o(term[c]));
  end

  // |sum| stays below 2^62, so the floor fits the output without clipping
  assign sum_all = term[0] + term[1] + term[2];

  always_ff @(posedge clk) begin
    if (en) begin
      out_noise_r <= sum_all[63:32];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(smp_r) && $stable(ld_r))
    else $error("pipeline tokens moved during stall");

  a_tbl_only_load: assert property (@(posedge clk) disable iff (!rst_n)
    !tbl_we |=> $stable(dvalid_r))
    else $error("direction valid bits changed without a load");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_r & smp_r[LdN-1:0]) == '0)
    else $error("load and sample share a stage");

  a_out_from_smp: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> out_valid_r == $past(smp_r[SmpN-1]))
    else $error("output valid does not follow last sample stage");

endmodule

[rtl/snd_ram.sv]
// ----------------------------------------------------------------------------
// snd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module snd_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/snd_hash.sv]
// ----------------------------------------------------------------------------
// snd_hash: lattice hash, four register stages
// Linear congruential step mod 2^32, read as signed, reduced mod DirCount
// by reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module snd_hash #(
  parameter int DirCount = snd_pkg::DIR_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [31:0]                 key_i,
  output logic [$clog2(DirCount)-1:0] hash_o
);

  localparam int IdxW = $clog2(DirCount);
  localparam int RemW = IdxW + 1;
  localparam logic [32:0] Recip = 33'((65'd1 << (32 + IdxW)) / DirCount);
  localparam logic [RemW-1:0] NumR  = RemW'(DirCount);
  localparam logic [RemW-1:0] WrapC = RemW'((64'd1 << 32) % DirCount);

  logic [31:0]     w_r, w_nxt;
  logic [31:0]     w2_r;
  logic [31:0]     q_r, q_nxt;
  logic [64:0]     prod;
  logic [RemW-1:0] rem_r, rem_nxt;
  logic            neg_r;
  logic [RemW-1:0] red;
  logic [IdxW-1:0] hash_r, hash_nxt;

  assign w_nxt   = key_i * snd_pkg::HASH_MUL + 32'd1;
  assign prod    = 65'(w_r) * 65'(Recip);
  assign q_nxt   = 32'(prod >> (32 + IdxW));
  assign rem_nxt = RemW'(w2_r - q_r * 32'(DirCount));
  assign red     = (rem_r >= NumR) ? rem_r - NumR : rem_r;

  always_comb begin
    if (!neg_r) begin
      hash_nxt = IdxW'(red);
    end else if (red >= WrapC) begin
      hash_nxt = IdxW'(red - WrapC);
    end else begin
      hash_nxt = IdxW'(red + NumR - WrapC);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r    <= w_nxt;
      w2_r   <= w_r;
      q_r    <= q_nxt;
      rem_r  <= rem_nxt;
      neg_r  <= w2_r[31];
      hash_r <= hash_nxt;
    end
  end

  assign hash_o = hash_r;

endmodule

[rtl/snd_corner.sv]
// ----------------------------------------------------------------------------
// snd_corner: one simplex corner, stages S3..S15
// Offset from the corner, radial falloff to the fourth power, dot product
// with the gradient (arriving at S12) and the weighted term.
// ----------------------------------------------------------------------------
module snd_corner (
  input  logic                clk,
  input  logic                en,
  input  logic signed [31:0]  x_i,
  input  logic signed [31:0]  y_i,
  input  logic signed [18:0]  a_i,
  input  logic signed [18:0]  b_i,
  input  logic [15:0]         g2_i,
  input  snd_pkg::grad_t      grad_i,
  output logic signed [63:0]  term_o
);

  localparam int DxDly = snd_pkg::DX_DELAY;
  localparam int M4Dly = snd_pkg::M4_DELAY;

  // S3
  logic signed [19:0] sab;
  logic signed [36:0] t3_r, t3_nxt;
  logic signed [39:0] bx3_r, bx3_nxt, by3_r, by3_nxt;
  // S4
  logic signed [39:0] dxf, dyf;
  logic signed [16:0] dx4_r, dy4_r;
  logic               far4_r, far4_nxt;
  // S5
  logic signed [33:0] sqx_full, sqy_full;
  logic [31:0]        sqx5_r, sqy5_r;
  logic               far5_r;
  // S6
  logic [32:0]        r2;
  logic [31:0]        m6_r, m6_nxt;
  logic               zero6_r, zero6_nxt;
  // S7
  logic [63:0]        mm;
  logic [30:0]        m27_r;
  logic               zero7_r;
  // S8
  logic [61:0]        mq;
  logic [28:0]        m48_r;
  logic               zero8_r;
  // delay lines
  logic signed [16:0] dxd_r [DxDly];
  logic signed [16:0] dyd_r [DxDly];
  logic [28:0]        m4d_r [M4Dly];
  logic               zd_r  [M4Dly];
  // S13..S15
  logic signed [32:0] px13_r, px13_nxt, py13_r, py13_nxt;
  logic signed [33:0] dot14_r, dot14_nxt;
  logic signed [63:0] term_r, term_nxt;

  assign sab     = 20'(a_i) + 20'(b_i);
  assign t3_nxt  = sab * $signed({1'b0, g2_i});
  assign bx3_nxt = 40'(x_i) - (40'(a_i) <<< 16);
  assign by3_nxt = 40'(y_i) - (40'(b_i) <<< 16);

  assign dxf      = bx3_r + 40'(t3_r);
  assign dyf      = by3_r + 40'(t3_r);
  assign far4_nxt = (dxf >= 40'sd65536) || (dxf <= -40'sd65536) ||
                    (dyf >= 40'sd65536) || (dyf <= -40'sd65536);

  assign sqx_full = dx4_r * dx4_r;
  assign sqy_full = dy4_r * dy4_r;

  assign r2        = {1'b0, sqx5_r} + {1'b0, sqy5_r};
  assign zero6_nxt = far5_r || (r2 >= snd_pkg::HALF_Q32);
  assign m6_nxt    = 32'(snd_pkg::HALF_Q32 - r2);

  assign mm = 64'(m6_r) * 64'(m6_r);
  assign mq = 62'(m27_r) * 62'(m27_r);

  assign px13_nxt  = dxd_r[DxDly-1] * grad_i.gx;
  assign py13_nxt  = dyd_r[DxDly-1] * grad_i.gy;
  assign dot14_nxt = 34'(px13_r) + 34'(py13_r);
  assign term_nxt  = zd_r[M4Dly-1] ? '0 :
                     64'($signed({1'b0, m4d_r[M4Dly-1]})) * 64'(dot14_r);

  always_ff @(posedge clk) begin
    if (en) begin
      t3_r    <= t3_nxt;
      bx3_r   <= bx3_nxt;
      by3_r   <= by3_nxt;
      dx4_r   <= dxf[16:0];
      dy4_r   <= dyf[16:0];
      far4_r  <= far4_nxt;
      sqx5_r  <= sqx_full[31:0];
      sqy5_r  <= sqy_full[31:0];
      far5_r  <= far4_r;
      m6_r    <= m6_nxt;
      zero6_r <= zero6_nxt;
      m27_r   <= mm[62:32];
      zero7_r <= zero6_r;
      m48_r   <= mq[60:32];
      zero8_r <= zero7_r;
      dxd_r[0] <= dx4_r;
      dyd_r[0] <= dy4_r;
      for (int k = 1; k < DxDly; k++) begin
        dxd_r[k] <= dxd_r[k-1];
        dyd_r[k] <= dyd_r[k-1];
      end
      m4d_r[0] <= m48_r;
      zd_r[0]  <= zero8_r;
      for (int k = 1; k < M4Dly; k++) begin
        m4d_r[k] <= m4d_r[k-1];
        zd_r[k]  <= zd_r[k-1];
      end
      px13_r  <= px13_nxt;
      py13_r  <= py13_nxt;
      dot14_r <= dot14_nxt;
      term_r  <= term_nxt;
    end
  end

  assign term_o = term_r;

endmodule
